// ===== hw/rtl/h_bdts_pkg.sv =====
// Package for the H-bridge dead-time sequencer: phase codes, gate bit
// positions, counter width and stream field layout. No dependencies.
package h_bdts_pkg;

    // Wait counter width; the wait limit saturates at its maximum.
    localparam int CountWidth  = 16;
    localparam int DeadWidth   = 16;
    localparam int LimitWidth  = (CountWidth > DeadWidth) ? CountWidth : DeadWidth;

    localparam logic [DeadWidth-1:0] DeadTimeReset = DeadWidth'(100);

    typedef logic [CountWidth-1:0] t_count;
    typedef logic [DeadWidth-1:0]  t_dead;
    typedef logic [3:0]            t_phase;
    typedef logic [3:0]            t_gates;
    typedef logic [1:0]            t_mode;

    // Gate bit positions: high sides active low, low sides active high.
    localparam int GateHl = 0;
    localparam int GateHr = 1;
    localparam int GateLl = 2;
    localparam int GateLr = 3;

    localparam t_gates GatesHigh = t_gates'((1 << GateHl) | (1 << GateHr));
    localparam t_gates GatesLow  = t_gates'((1 << GateLl) | (1 << GateLr));
    localparam t_gates GateBitHr = t_gates'(1 << GateHr);
    localparam t_gates GateBitHl = t_gates'(1 << GateHl);
    localparam t_gates GateBitLl = t_gates'(1 << GateLl);
    localparam t_gates GateBitLr = t_gates'(1 << GateLr);

    // Sequencer phases.
    localparam t_phase PhPuStart  = 4'd0;
    localparam t_phase PhPuWait1  = 4'd1;
    localparam t_phase PhPuWait2  = 4'd2;
    localparam t_phase PhSample   = 4'd3;
    localparam t_phase PhBrkWait  = 4'd4;
    localparam t_phase PhFwdWait1 = 4'd5;
    localparam t_phase PhFwdWait2 = 4'd6;
    localparam t_phase PhFwdHold  = 4'd7;
    localparam t_phase PhRevWait1 = 4'd8;
    localparam t_phase PhRevWait2 = 4'd9;
    localparam t_phase PhRevHold  = 4'd10;

    localparam t_mode ModeStartup = 2'd0;
    localparam t_mode ModeBrake   = 2'd1;
    localparam t_mode ModeForward = 2'd2;
    localparam t_mode ModeReverse = 2'd3;

    localparam int InDataWidth  = 8;
    localparam int OutDataWidth = 8;

    function automatic t_mode mode_of(input t_phase ph);
        t_mode m;
        if (ph <= PhPuWait2) begin
            m = ModeStartup;
        end else if (ph >= PhFwdWait1 && ph <= PhFwdHold) begin
            m = ModeForward;
        end else if (ph >= PhRevWait1 && ph <= PhRevHold) begin
            m = ModeReverse;
        end else begin
            m = ModeBrake;
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/h_bridge_dead_time_sequencer_unit.sv =====
// H-bridge dead-time sequencer: phase/wait state machine with a registered
// stream output. Depends on h_bdts_pkg.
//
// The result of an input transfer is on the output register in the next cycle.
// The unit takes one item per cycle unless the output stalls; the output
// register accepts a new item in the cycle its current result is taken.
// Reset (synchronous, active low): power-up phase, wait count zero, all gate
// pins low, dead_time 100, no result pending.
module h_bridge_dead_time_sequencer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [h_bdts_pkg::DeadWidth-1:0]    i_cfg_wr_data,    // dead_time
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [h_bdts_pkg::InDataWidth-1:0]  i_s_axis_tdata,   // [0] fwd_level, [1] rev_level
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [h_bdts_pkg::OutDataWidth-1:0] o_m_axis_tdata    // [0] high_left_pin,
                                                                  // [1] high_right_pin,
                                                                  // [2] low_left_pin,
                                                                  // [3] low_right_pin,
                                                                  // [5:4] drive_mode
);
    import h_bdts_pkg::*;

    localparam logic [LimitWidth-1:0] CountMax = LimitWidth'({CountWidth{1'b1}});

    t_dead   r_dead_time;
    t_phase  r_phase, n_phase;
    t_count  r_wait_cnt, n_wait_cnt;
    t_gates  r_gates, n_gates;
    logic    r_out_valid;
    logic [OutDataWidth-1:0] r_out_data;

    logic                  in_xfer;
    logic                  fwd, rev;
    logic [LimitWidth-1:0] dead_ext, limit;
    logic                  wait_over;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign fwd             = i_s_axis_tdata[0];
    assign rev             = i_s_axis_tdata[1];

    assign dead_ext  = LimitWidth'(r_dead_time);
    assign limit     = (dead_ext > CountMax) ? CountMax : dead_ext;
    assign wait_over = !(LimitWidth'(r_wait_cnt) < limit);

    always_comb begin
        n_phase    = r_phase;
        n_wait_cnt = r_wait_cnt;
        n_gates    = r_gates;
        if (!wait_over) begin
            // only used in wait phases; other phases ignore this default
            n_wait_cnt = r_wait_cnt + t_count'(1);
        end
        unique case (r_phase)
            PhPuStart: begin
                n_gates = r_gates & ~GatesHigh;
                n_wait_cnt = '0;
                n_phase = PhPuWait1;
            end
            PhPuWait1: begin
                if (wait_over) begin
                    n_gates = r_gates | GatesHigh;
                    n_wait_cnt = '0;
                    n_phase = PhPuWait2;
                end
            end
            PhPuWait2, PhBrkWait: begin
                if (wait_over) begin
                    n_gates = r_gates | GatesLow;
                    n_wait_cnt = '0;
                    n_phase = PhSample;
                end
            end
            PhFwdWait1: begin
                if (wait_over) begin
                    n_gates = r_gates & ~GateBitHr;
                    n_wait_cnt = '0;
                    n_phase = PhFwdWait2;
                end
            end
            PhFwdWait2: begin
                if (wait_over) begin
                    n_gates = r_gates | GateBitLl;
                    n_wait_cnt = '0;
                    n_phase = PhFwdHold;
                end
            end
            PhRevWait1: begin
                if (wait_over) begin
                    n_gates = r_gates & ~GateBitHl;
                    n_wait_cnt = '0;
                    n_phase = PhRevWait2;
                end
            end
            PhRevWait2: begin
                if (wait_over) begin
                    n_gates = r_gates | GateBitLr;
                    n_wait_cnt = '0;
                    n_phase = PhRevHold;
                end
            end
            default: begin
                // sample; hold phases only resample once commands are equal
                n_wait_cnt = r_wait_cnt;
                if (fwd == rev) begin
                    n_gates = r_gates | GatesHigh;
                    n_wait_cnt = '0;
                    n_phase = PhBrkWait;
                end else if (r_phase != PhFwdHold && r_phase != PhRevHold) begin
                    n_gates = r_gates & ~GatesLow;
                    n_wait_cnt = '0;
                    n_phase = fwd ? PhFwdWait1 : PhRevWait1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_time <= DeadTimeReset;
            r_phase     <= PhPuStart;
            r_wait_cnt  <= '0;
            r_gates     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_dead_time <= i_cfg_wr_data;
            end
            if (in_xfer) begin
                r_phase     <= n_phase;
                r_wait_cnt  <= n_wait_cnt;
                r_gates     <= n_gates;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= {2'b00, mode_of(n_phase), n_gates};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // a high side on with the low side of its own leg on is shoot-through
    a_no_shoot_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(!r_gates[GateHl] && r_gates[GateLl]))
        else $error("left leg shoot-through");

    a_no_shoot_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(!r_gates[GateHr] && r_gates[GateLr]))
        else $error("right leg shoot-through");

    a_fwd_hold_gates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PhFwdHold) |-> (r_gates == (GateBitHl | GateBitLl)))
        else $error("forward hold with wrong gate levels");

    a_xfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("accepted item produced no result");

    a_state_only_on_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_xfer |=> ($stable(r_gates) && $stable(r_phase)))
        else $error("state changed without an input transfer");
`endif

endmodule
